[src/rcfp_pkg.sv]
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types, constants and lookup functions for the radio command frame
// parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  // Default frame length limit in bytes
  localparam int unsigned MAX_FRAME_BYTES_DEF = 251;

  // Frame scanner widths
  localparam int unsigned POS_W   = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COMMA_W = 3;

  // Keyword table: ARM, NULL (field 0), LAUNCH (field 1), PARACHUTE, NULL (field 2)
  localparam int unsigned KW_COUNT = 5;
  localparam int unsigned KW_MAX   = 9;
  localparam int unsigned KW_BITS  = 8 * KW_MAX;

  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    {"ARM",       48'h0},
    {"NULL",      40'h0},
    {"LAUNCH",    24'h0},
    {"PARACHUTE"       },
    {"NULL",      40'h0}
  };
  localparam logic [IDX_W-1:0]   KW_LEN   [KW_COUNT] = '{8'd3, 8'd4, 8'd6, 8'd9, 8'd4};
  localparam logic [COMMA_W-1:0] KW_FIELD [KW_COUNT] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2};

  // Keyword hit bit positions
  localparam int unsigned HIT_ARM    = 0;
  localparam int unsigned HIT_DISARM = 1;
  localparam int unsigned HIT_LAUNCH = 2;
  localparam int unsigned HIT_DEPLOY = 3;
  localparam int unsigned HIT_STOW   = 4;

  // Frame markers
  localparam logic [47:0] START_TEXT = "START,";
  localparam logic [2:0]  START_LEN  = 3'd6;
  localparam logic [31:0] TAIL_END   = 32'h2C45_4E44;  // ",END"
  localparam logic [2:0]  END_LEN    = 3'd4;
  localparam logic [7:0]  CHAR_COMMA = 8'h2C;
  localparam logic [7:0]  CHAR_NUL   = 8'h00;
  localparam logic [COMMA_W-1:0] COMMA_SAT  = 3'd6;
  localparam logic [COMMA_W-1:0] COMMA_GOOD = 3'd5;
  localparam logic [IDX_W-1:0]   IDX_SAT    = 8'd255;

  // Result codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MARKER = 2'd1;
  localparam logic [1:0] ST_COMMAS = 2'd2;

  localparam logic [1:0] CHUTE_NONE   = 2'd0;
  localparam logic [1:0] CHUTE_DEPLOY = 2'd1;
  localparam logic [1:0] CHUTE_STOW   = 2'd2;

  // Frame summary after the current byte, scanner to command logic
  typedef struct packed {
    logic                start_ok;
    logic                end_ok;
    logic                comma_five;
    logic [KW_COUNT-1:0] hits;
  } scan_sum_t;

  // Character i of keyword k (only used where i is below the keyword length)
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] i);
    logic [KW_BITS-1:0] w;
    w = KW_TEXT[k] << {i, 3'b000};
    return w[KW_BITS-1 -: 8];
  endfunction

  // Character i of the start marker (i below START_LEN)
  function automatic logic [7:0] start_char(input logic [2:0] i);
    logic [47:0] w;
    w = START_TEXT << {i, 3'b000};
    return w[47:40];
  endfunction

endpackage

[src/rcfp_scan.sv]
// ----------------------------------------------------------------------------
// rcfp_scan
// Per-frame scanner: start/end marker checks, comma counting and keyword
// matching. Presents the frame summary as it stands after the current beat.
// ----------------------------------------------------------------------------
module rcfp_scan #(
  parameter int unsigned MAX_FRAME_BYTES = rcfp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                last_in,
  output rcfp_pkg::scan_sum_t sum
);
  import rcfp_pkg::*;

  localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_FRAME_BYTES);

  logic [POS_W-1:0]    position,    position_next;
  logic                terminated,  terminated_next;
  logic                prefix_ok,   prefix_ok_next;
  logic [31:0]         tail_window, tail_window_next;
  logic [COMMA_W-1:0]  comma_count, comma_count_next;
  logic [IDX_W-1:0]    char_index,  char_index_next;
  logic [KW_COUNT-1:0] match_bits,  match_bits_next;
  logic [KW_COUNT-1:0] hits,        hits_next;

  // Next per-frame state for the beat in the input register
  always_comb begin
    position_next    = position;
    terminated_next  = terminated;
    prefix_ok_next   = prefix_ok;
    tail_window_next = tail_window;
    comma_count_next = comma_count;
    char_index_next  = char_index;
    match_bits_next  = match_bits;
    hits_next        = hits;
    if (!terminated && position < MaxPos) begin
      if (byte_in == CHAR_NUL) begin
        terminated_next = 1'b1;
      end else begin
        if (position < POS_W'(START_LEN) && byte_in != start_char(position[2:0])) begin
          prefix_ok_next = 1'b0;
        end
        tail_window_next = {tail_window[23:0], byte_in};
        if (byte_in == CHAR_COMMA) begin
          if (comma_count < COMMA_SAT) begin
            // close field 0..2: record keywords that matched in full
            if (comma_count >= 3'd1 && comma_count <= 3'd3) begin
              for (int k = 0; k < KW_COUNT; k++) begin
                if (KW_FIELD[k] == comma_count - 3'd1 && match_bits[k] &&
                    char_index == KW_LEN[k]) begin
                  hits_next[k] = 1'b1;
                end
              end
            end
            comma_count_next = comma_count + 3'd1;
          end
          char_index_next = '0;
          match_bits_next = '1;
        end else begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if (char_index >= KW_LEN[k] || byte_in != kw_char(k, char_index[3:0])) begin
              match_bits_next[k] = 1'b0;
            end
          end
          if (char_index != IDX_SAT) begin
            char_index_next = char_index + 8'd1;
          end
        end
        position_next = position + 8'd1;
      end
    end
  end

  // Summary as seen after this beat
  always_comb begin
    sum.start_ok   = (position_next >= POS_W'(START_LEN)) && prefix_ok_next;
    sum.end_ok     = (position_next >= POS_W'(END_LEN)) && (tail_window_next == TAIL_END);
    sum.comma_five = (comma_count_next == COMMA_GOOD);
    sum.hits       = hits_next;
  end

  // Frame state registers; cleared after the last beat of a frame
  always_ff @(posedge clk) begin
    if (rst || (step && last_in)) begin
      position    <= '0;
      terminated  <= 1'b0;
      prefix_ok   <= 1'b1;
      tail_window <= '0;
      comma_count <= '0;
      char_index  <= '0;
      match_bits  <= '1;
      hits        <= '0;
    end else if (step) begin
      position    <= position_next;
      terminated  <= terminated_next;
      prefix_ok   <= prefix_ok_next;
      tail_window <= tail_window_next;
      comma_count <= comma_count_next;
      char_index  <= char_index_next;
      match_bits  <= match_bits_next;
      hits        <= hits_next;
    end
  end

endmodule

[src/rcfp_cmd.sv]
// ----------------------------------------------------------------------------
// rcfp_cmd
// Frame verdict and command decode: keeps the sticky arm, launch and
// parachute flags and holds the result register.
// ----------------------------------------------------------------------------
module rcfp_cmd (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rcfp_pkg::scan_sum_t sum,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          frame_status,
  output logic                armed,
  output logic                launch_ordered,
  output logic                chute_flag,
  output logic                disarm_pulse,
  output logic [1:0]          chute_action
);
  import rcfp_pkg::*;

  logic       arm_flag,    arm_flag_next;
  logic       launch_flag, launch_flag_next;
  logic       chute,       chute_next;
  logic [1:0] status_next;
  logic       disarm_next;
  logic [1:0] action_next;

  // Verdict and flag updates
  always_comb begin
    arm_flag_next    = arm_flag;
    launch_flag_next = launch_flag;
    chute_next       = chute;
    disarm_next      = 1'b0;
    action_next      = CHUTE_NONE;
    if (!(sum.start_ok && sum.end_ok)) begin
      status_next = ST_MARKER;
    end else if (!sum.comma_five) begin
      status_next = ST_COMMAS;
    end else begin
      status_next = ST_OK;
      if (sum.hits[HIT_ARM] && !arm_flag) begin
        arm_flag_next = 1'b1;
      end else if (sum.hits[HIT_DISARM] && arm_flag) begin
        arm_flag_next = 1'b0;
        disarm_next   = 1'b1;
      end
      if (sum.hits[HIT_LAUNCH]) begin
        launch_flag_next = 1'b1;
      end
      if (sum.hits[HIT_DEPLOY]) begin
        chute_next  = 1'b1;
        action_next = CHUTE_DEPLOY;
      end else if (sum.hits[HIT_STOW]) begin
        chute_next  = 1'b0;
        action_next = CHUTE_STOW;
      end
    end
  end

  // Sticky flags and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      arm_flag    <= 1'b0;
      launch_flag <= 1'b0;
      chute       <= 1'b0;
      out_valid   <= 1'b0;
    end else if (load) begin
      arm_flag    <= arm_flag_next;
      launch_flag <= launch_flag_next;
      chute       <= chute_next;
      out_valid   <= 1'b1;
    end else if (out_ready) begin
      out_valid   <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      frame_status   <= status_next;
      armed          <= arm_flag_next;
      launch_ordered <= launch_flag_next;
      chute_flag     <= chute_next;
      disarm_pulse   <= disarm_next;
      chute_action   <= action_next;
    end
  end

endmodule

[src/radio_command_frame_parser.sv]
// ----------------------------------------------------------------------------
// radio_command_frame_parser
// Parses radio command frames one byte per beat and emits one result per
// frame with the status and the updated arm, launch and parachute flags.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_ready  | frame_byte[7:0], last_byte
//   result  | out_valid / out_ready| frame_status[1:0], armed, launch_ordered,
//           |                      | chute_flag, disarm_pulse, chute_action[1:0]
//
// One byte is accepted per cycle while input is not stalled. A byte is held in
// the input register and scanned, and a last byte then loads the result
// register, which then presents the result with out_valid. Only a last byte
// waiting on a full, unread result register stalls input. Synchronous reset
// clears the sticky flags and the frame state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module radio_command_frame_parser #(
  parameter int unsigned MAX_FRAME_BYTES = rcfp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] frame_status,
  output logic       armed,
  output logic       launch_ordered,
  output logic       chute_flag,
  output logic       disarm_pulse,
  output logic [1:0] chute_action
);
  import rcfp_pkg::*;

  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;
  logic       advance;
  scan_sum_t  sum;

  // A non-last beat never needs the result register
  assign advance  = s_valid && (!s_last || !out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte <= frame_byte;
      s_last <= last_byte;
    end
  end

  rcfp_scan #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .byte_in(s_byte),
    .last_in(s_last),
    .sum    (sum)
  );

  rcfp_cmd u_cmd (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && s_last),
    .sum           (sum),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .frame_status  (frame_status),
    .armed         (armed),
    .launch_ordered(launch_ordered),
    .chute_flag    (chute_flag),
    .disarm_pulse  (disarm_pulse),
    .chute_action  (chute_action)
  );

  // Rejected frames carry no command action
  a_reject_no_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != ST_OK |-> !disarm_pulse && chute_action == CHUTE_NONE)
    else $error("rejected frame carries an action");

  // Disarm pulse leaves the arm flag clear
  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && disarm_pulse |-> !armed)
    else $error("disarm pulse with arm flag set");

  // Chute action agrees with the chute flag
  a_chute_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (chute_action == CHUTE_DEPLOY || chute_action == CHUTE_STOW)
    |-> chute_flag == (chute_action == CHUTE_DEPLOY))
    else $error("chute action and flag disagree");

  // A last beat blocked by an unread result is held, not dropped
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_last && out_valid && !out_ready |=> s_valid && s_last && out_valid)
    else $error("blocked last beat lost");

endmodule
